[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define LFPD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lfpd: property violated");
`define LFPD_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("lfpd: forbidden condition seen");
`else
`define LFPD_ASSERT(lbl, prop)
`define LFPD_NEVER(lbl, cond)
`endif

`endif

[rtl/lfpd_pkg.sv]
// ----------------------------------------------------------------------------
// lfpd_pkg
// Types, constants and weight tables of the line follower PD step.
// ----------------------------------------------------------------------------
package lfpd_pkg;

  localparam int NumSensors  = 5;
  localparam int SampleBits  = 10;
  localparam int ThreshBits  = 10;
  localparam int CmpBits     = (SampleBits > ThreshBits) ? SampleBits : ThreshBits;
  localparam int GainBits    = 8;
  localparam int ErrBits     = 5;
  localparam int DerivBits   = ErrBits + 1;
  localparam int AluBits     = 16;
  localparam int DutyBits    = 8;
  localparam int DriveLimit  = 255;
  localparam int LostError   = 15;
  localparam int LostSplit   = 5;
  localparam int CfgIdxBits  = 2;
  localparam int CfgDataBits = 10;
  localparam int SensIdxBits = $clog2(NumSensors);
  localparam int CntBits     = $clog2(NumSensors + 1);
  localparam int MaxSteps0   = (GainBits > NumSensors) ? GainBits : NumSensors;
  localparam int MaxSteps    = (MaxSteps0 > ErrBits) ? MaxSteps0 : ErrBits;
  localparam int ItBits      = $clog2(MaxSteps);

  localparam logic [ThreshBits-1:0] ThresholdRst = ThreshBits'(250);
  localparam logic [GainBits-1:0]   KpRst        = GainBits'(20);
  localparam logic [GainBits-1:0]   KdRst        = GainBits'(20);
  localparam logic [GainBits-1:0]   BaseSpeedRst = GainBits'(200);

  typedef logic signed [AluBits-1:0] word_t;
  typedef logic signed [ErrBits-1:0] err_t;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgThreshold = 2'd0,
    CfgKp        = 2'd1,
    CfgKd        = 2'd2,
    CfgBaseSpeed = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OvsNone  = 2'd0,
    OvsLeft  = 2'd1,
    OvsRight = 2'd2
  } ovs_e;

  typedef enum logic [3:0] {
    StIdle,
    StScan,
    StAbs,
    StDiv,
    StSign,
    StLost,
    StDeriv,
    StMulP,
    StMulD,
    StLeft,
    StRight,
    StDone
  } state_e;

  typedef struct packed {
    logic [ThreshBits-1:0] threshold;
    logic [GainBits-1:0]   kp;
    logic [GainBits-1:0]   kd;
    logic [GainBits-1:0]   base_speed;
  } cfg_t;

  typedef struct packed {
    word_t a;
    word_t b;
    logic  sub;
  } alu_op_t;

  // Sensor weight, left to right; damped set applies while overshooting.
  function automatic err_t weight(input logic damped, input logic [SensIdxBits-1:0] idx);
    err_t w;
    w = '0;
    case (idx)
      3'd0:    w = damped ? err_t'(-3) : err_t'(-15);
      3'd1:    w = damped ? err_t'(-2) : err_t'(-5);
      3'd2:    w = '0;
      3'd3:    w = damped ? err_t'(2)  : err_t'(5);
      3'd4:    w = damped ? err_t'(3)  : err_t'(15);
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

[rtl/lfpd_in_if.sv]
// ----------------------------------------------------------------------------
// lfpd_in_if
// Sample channel: five reflectance samples per transfer.
// ----------------------------------------------------------------------------
interface lfpd_in_if import lfpd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [SampleBits-1:0] sample_left;
  logic [SampleBits-1:0] sample_mid_left;
  logic [SampleBits-1:0] sample_mid;
  logic [SampleBits-1:0] sample_mid_right;
  logic [SampleBits-1:0] sample_right;

  modport source (
    output valid, sample_left, sample_mid_left, sample_mid, sample_mid_right, sample_right,
    input  ready
  );

  modport sink (
    input  valid, sample_left, sample_mid_left, sample_mid, sample_mid_right, sample_right,
    output ready
  );
endinterface

[rtl/lfpd_out_if.sv]
// ----------------------------------------------------------------------------
// lfpd_out_if
// Result channel: motor commands, line error and overshoot flag.
// ----------------------------------------------------------------------------
interface lfpd_out_if import lfpd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DutyBits-1:0] left_duty;
  logic                left_reverse;
  logic [DutyBits-1:0] right_duty;
  logic                right_reverse;
  logic signed [ErrBits-1:0] line_error;
  logic [1:0]          overshoot_flag;

  modport source (
    output valid, left_duty, left_reverse, right_duty, right_reverse, line_error,
           overshoot_flag,
    input  ready
  );

  modport sink (
    input  valid, left_duty, left_reverse, right_duty, right_reverse, line_error,
           overshoot_flag,
    output ready
  );
endinterface

[rtl/lfpd_alu.sv]
// ----------------------------------------------------------------------------
// lfpd_alu
// Shared adder/subtractor used by every arithmetic step of the sequencer.
// ----------------------------------------------------------------------------
module lfpd_alu import lfpd_pkg::*; (
  input  alu_op_t op_i,
  output word_t   y_o
);

  assign y_o = op_i.sub ? (op_i.a - op_i.b) : (op_i.a + op_i.b);

endmodule

[rtl/lfpd_core.sv]
// ----------------------------------------------------------------------------
// lfpd_core
// Sequencer and datapath: weight scan, restoring divide, shift-add PD products
// and motor commands, all through one adder, then saturation of the commands.
// ----------------------------------------------------------------------------
module lfpd_core import lfpd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  lfpd_in_if.sink           item_i,
  lfpd_out_if.source        result_o
);

  state_e state_q, state_d;

  logic [SampleBits-1:0] samp_q [NumSensors];
  word_t                 acc_q, lcmd_q;
  logic [ItBits-1:0]     it_q;
  logic [CntBits-1:0]    cnt_q, cnt_nx;
  logic [CntBits-1:0]    rem_q;
  logic [ErrBits-1:0]    quo_q;
  logic                  neg_q;
  err_t                  err_q, prev_q, last_q;
  logic signed [DerivBits-1:0] deriv_q;
  ovs_e                  ovs_q;

  logic                  out_valid_q;
  logic [DutyBits-1:0]   l_duty_q, r_duty_q;
  logic                  l_rev_q, r_rev_q;
  err_t                  o_err_q;
  ovs_e                  o_ovs_q;

  alu_op_t               alu_op;
  word_t                 alu_y;
  logic                  active;
  logic                  accept, load;
  logic                  it_last_scan, it_last_div, it_last_mul;
  logic [SensIdxBits-1:0] sens_idx;
  err_t                  w;
  logic [DutyBits:0]     l_sat, r_sat;

  function automatic logic [DutyBits:0] sat_drive(input word_t v);
    word_t c;
    word_t m;
    if (v > word_t'(DriveLimit)) begin
      c = word_t'(DriveLimit);
    end else if (v < word_t'(-DriveLimit)) begin
      c = word_t'(-DriveLimit);
    end else begin
      c = v;
    end
    m = c[AluBits-1] ? -c : c;
    return {c[AluBits-1], m[DutyBits-1:0]};
  endfunction

  lfpd_alu u_alu (
    .op_i (alu_op),
    .y_o  (alu_y)
  );

  assign sens_idx     = it_q[SensIdxBits-1:0];
  assign w            = weight(ovs_q != OvsNone, sens_idx);
  assign active       = CmpBits'(samp_q[sens_idx]) < CmpBits'(cfg_i.threshold);
  assign cnt_nx       = cnt_q + CntBits'(active);
  assign it_last_scan = it_q == ItBits'(NumSensors - 1);
  assign it_last_div  = it_q == ItBits'(ErrBits - 1);
  assign it_last_mul  = it_q == ItBits'(GainBits - 1);
  assign accept       = item_i.valid && item_i.ready;
  assign load         = (state_q == StDone) && (!out_valid_q || result_o.ready);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (item_i.valid) state_d = StScan;
      StScan:  if (it_last_scan) state_d = (cnt_nx == '0) ? StLost : StAbs;
      StAbs:   state_d = StDiv;
      StDiv:   if (it_last_div) state_d = StSign;
      StSign:  state_d = StDeriv;
      StLost:  state_d = StDeriv;
      StDeriv: state_d = StMulP;
      StMulP:  if (it_last_mul) state_d = StMulD;
      StMulD:  if (it_last_mul) state_d = StLeft;
      StLeft:  state_d = StRight;
      StRight: state_d = StDone;
      StDone:  if (load) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // adder operands
  always_comb begin
    alu_op.a   = acc_q;
    alu_op.b   = '0;
    alu_op.sub = 1'b0;
    case (state_q)
      StScan: begin
        alu_op.b = active ? {{(AluBits-ErrBits){w[ErrBits-1]}}, w} : '0;
      end
      StAbs: begin
        alu_op.a   = '0;
        alu_op.b   = acc_q;
        alu_op.sub = 1'b1;
      end
      StDiv: begin
        alu_op.a   = {{(AluBits-CntBits-1){1'b0}}, rem_q, quo_q[ErrBits-1]};
        alu_op.b   = {{(AluBits-CntBits){1'b0}}, cnt_q};
        alu_op.sub = 1'b1;
      end
      StSign: begin
        alu_op.a   = '0;
        alu_op.b   = {{(AluBits-ErrBits){1'b0}}, quo_q};
        alu_op.sub = neg_q;
      end
      StDeriv: begin
        alu_op.a   = {{(AluBits-ErrBits){err_q[ErrBits-1]}}, err_q};
        alu_op.b   = {{(AluBits-ErrBits){prev_q[ErrBits-1]}}, prev_q};
        alu_op.sub = 1'b1;
      end
      StMulP: begin
        alu_op.b = cfg_i.kp[it_q] ?
                   ({{(AluBits-ErrBits){err_q[ErrBits-1]}}, err_q} <<< it_q) : '0;
      end
      StMulD: begin
        alu_op.b = cfg_i.kd[it_q] ?
                   ({{(AluBits-DerivBits){deriv_q[DerivBits-1]}}, deriv_q} <<< it_q) : '0;
      end
      StLeft: begin
        alu_op.a = {{(AluBits-GainBits){1'b0}}, cfg_i.base_speed};
        alu_op.b = acc_q;
      end
      StRight: begin
        alu_op.a   = {{(AluBits-GainBits){1'b0}}, cfg_i.base_speed};
        alu_op.b   = acc_q;
        alu_op.sub = 1'b1;
      end
      default: begin
        alu_op.a = acc_q;
      end
    endcase
  end

  // control and step state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      it_q    <= '0;
      cnt_q   <= '0;
      err_q   <= '0;
      prev_q  <= '0;
      last_q  <= '0;
      ovs_q   <= OvsNone;
    end else begin
      state_q <= state_d;
      case (state_q)
        StIdle: begin
          it_q  <= '0;
          cnt_q <= '0;
        end
        StScan: begin
          cnt_q <= cnt_nx;
          it_q  <= it_last_scan ? '0 : it_q + 1'b1;
        end
        StDiv: begin
          it_q <= it_last_div ? '0 : it_q + 1'b1;
        end
        StSign: begin
          err_q  <= alu_y[ErrBits-1:0];
          last_q <= alu_y[ErrBits-1:0];
        end
        StLost: begin
          if (last_q < err_t'(LostSplit)) begin
            err_q <= err_t'(-LostError);
            ovs_q <= OvsLeft;
          end else if (last_q > err_t'(LostSplit)) begin
            err_q <= err_t'(LostError);
            ovs_q <= OvsRight;
          end else begin
            err_q <= '0;
          end
        end
        StDeriv: begin
          prev_q <= err_q;
          it_q   <= '0;
          if ((ovs_q == OvsLeft && !err_q[ErrBits-1]) ||
              (ovs_q == OvsRight && (err_q[ErrBits-1] || err_q == '0))) begin
            ovs_q <= OvsNone;
          end
        end
        StMulP, StMulD: begin
          it_q <= it_last_mul ? '0 : it_q + 1'b1;
        end
        default: begin
          it_q <= it_q;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (accept) begin
          samp_q[0] <= item_i.sample_left;
          samp_q[1] <= item_i.sample_mid_left;
          samp_q[2] <= item_i.sample_mid;
          samp_q[3] <= item_i.sample_mid_right;
          samp_q[4] <= item_i.sample_right;
        end
        acc_q <= '0;
      end
      StScan: acc_q <= alu_y;
      StAbs: begin
        neg_q <= acc_q[AluBits-1];
        quo_q <= acc_q[AluBits-1] ? alu_y[ErrBits-1:0] : acc_q[ErrBits-1:0];
        rem_q <= '0;
      end
      StDiv: begin
        if (!alu_y[AluBits-1]) begin
          rem_q <= alu_y[CntBits-1:0];
        end else begin
          rem_q <= {rem_q[CntBits-2:0], quo_q[ErrBits-1]};
        end
        quo_q <= {quo_q[ErrBits-2:0], ~alu_y[AluBits-1]};
      end
      StDeriv: begin
        deriv_q <= alu_y[DerivBits-1:0];
        acc_q   <= '0;
      end
      StMulP, StMulD: acc_q <= alu_y;
      StLeft:  lcmd_q <= alu_y;
      StRight: acc_q  <= alu_y;
      default: acc_q  <= acc_q;
    endcase
  end

  assign l_sat = sat_drive(lcmd_q);
  assign r_sat = sat_drive(acc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      l_rev_q  <= l_sat[DutyBits];
      l_duty_q <= l_sat[DutyBits-1:0];
      r_rev_q  <= r_sat[DutyBits];
      r_duty_q <= r_sat[DutyBits-1:0];
      o_err_q  <= err_q;
      o_ovs_q  <= ovs_q;
    end
  end

  assign item_i.ready            = state_q == StIdle;
  assign result_o.valid          = out_valid_q;
  assign result_o.left_duty      = l_duty_q;
  assign result_o.left_reverse   = l_rev_q;
  assign result_o.right_duty     = r_duty_q;
  assign result_o.right_reverse  = r_rev_q;
  assign result_o.line_error     = o_err_q;
  assign result_o.overshoot_flag = o_ovs_q;

endmodule

[rtl/line_follower_pd_step.sv]
// A new sample set is accepted only while idle, after the previous result is loaded.
// With the line lost, the abs, divide and sign steps are replaced by the lost step.
// Steps run on the single shared adder: one add per cycle for the weight
// scan (5), divide (5), kp and kd shift-add products (8 each) and the commands.
// Reset: asynchronous, active low; config registers return to defaults, state clears.
// ----------------------------------------------------------------------------
// line_follower_pd_step
// Line follower PD controller step: configuration registers and core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module line_follower_pd_step import lfpd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  lfpd_in_if.sink                item_i,
  lfpd_out_if.source             result_o,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_wdata_i
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold  <= ThresholdRst;
      cfg_q.kp         <= KpRst;
      cfg_q.kd         <= KdRst;
      cfg_q.base_speed <= BaseSpeedRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgThreshold: cfg_q.threshold  <= cfg_wdata_i[ThreshBits-1:0];
        CfgKp:        cfg_q.kp         <= cfg_wdata_i[GainBits-1:0];
        CfgKd:        cfg_q.kd         <= cfg_wdata_i[GainBits-1:0];
        CfgBaseSpeed: cfg_q.base_speed <= cfg_wdata_i[GainBits-1:0];
        default:      cfg_q            <= cfg_q;
      endcase
    end
  end

  lfpd_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .item_i   (item_i),
    .result_o (result_o)
  );

  `LFPD_ASSERT(a_busy_after_accept, item_i.valid && item_i.ready |=> !item_i.ready)
  `LFPD_ASSERT(a_flag_code, result_o.valid |-> (result_o.overshoot_flag == OvsNone || result_o.overshoot_flag == OvsLeft || result_o.overshoot_flag == OvsRight))
  `LFPD_ASSERT(a_left_lost_sign, result_o.valid && result_o.overshoot_flag == OvsLeft |-> result_o.line_error < 0)
  `LFPD_ASSERT(a_right_lost_sign, result_o.valid && result_o.overshoot_flag == OvsRight |-> result_o.line_error > 0)
  `LFPD_NEVER(a_reverse_nonzero, result_o.valid && result_o.left_reverse && result_o.left_duty == '0)

endmodule
